// File: rtl/core/vector_rotate_2d_defines.svh
// ----------------------------------------------------------------------------
// vector_rotate_2d assertion macros
// Shared concurrent checks for the rotator; the user expands them inside a
// module that has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_2D_DEFINES_SVH
`define VECTOR_ROTATE_2D_DEFINES_SVH

// same-cycle implication
`define VR2D_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_rotate_2d: check failed");

// implication after a fixed number of cycles
`define VR2D_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("vector_rotate_2d: delayed check failed");

`endif

// File: rtl/core/vr2d_pkg.sv
// ----------------------------------------------------------------------------
// vr2d_pkg
// Widths, angle constants, arctangent table and gain function of the rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package vr2d_pkg;

  localparam int VR2D_ITERATIONS = 24;
  localparam int VR2D_MAX_ITER   = 32;
  localparam int VR2D_IW         = 32;  // port field width
  localparam int VR2D_ZW         = 32;  // angle width inside the chain
  localparam int VR2D_DW         = 50;  // Q.32 datapath, covers gain growth
  localparam int VR2D_GUARD      = 16;
  localparam int VR2D_KW         = 31;  // gain compensation, unsigned Q.30

  localparam logic signed [VR2D_ZW:0] VR2D_ANG_PI      = 33'sd843314857;
  localparam logic signed [VR2D_ZW:0] VR2D_ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [VR2D_ZW:0] VR2D_ANG_TWO_PI  = 33'sd1686629713;

  typedef struct packed {
    logic signed [VR2D_DW-1:0] x;
    logic signed [VR2D_DW-1:0] y;
    logic signed [VR2D_ZW-1:0] z;
  } vr2d_vec_t;

  // round(atan(2^-i) * 2^28)
  function automatic logic [VR2D_ZW-1:0] vr2d_atan(input int i);
    logic [VR2D_ZW-1:0] v;
    case (i)
      0:  v = 32'd210828714;
      1:  v = 32'd124459457;
      2:  v = 32'd65760959;
      3:  v = 32'd33381290;
      4:  v = 32'd16755422;
      5:  v = 32'd8385879;
      6:  v = 32'd4193963;
      7:  v = 32'd2097109;
      8:  v = 32'd1048571;
      9:  v = 32'd524287;
      10: v = 32'd262144;
      11: v = 32'd131072;
      12: v = 32'd65536;
      13: v = 32'd32768;
      14: v = 32'd16384;
      15: v = 32'd8192;
      16: v = 32'd4096;
      17: v = 32'd2048;
      18: v = 32'd1024;
      19: v = 32'd512;
      20: v = 32'd256;
      21: v = 32'd128;
      22: v = 32'd64;
      23: v = 32'd32;
      24: v = 32'd16;
      25: v = 32'd8;
      26: v = 32'd4;
      27: v = 32'd2;
      28: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // K = floor(2^60 / floor(sqrt(P))), P = prod(1 + 4^-i) in Q.60; elaboration only
  function automatic logic [VR2D_KW-1:0] vr2d_gain_k(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_m;
    logic [63:0] rem;
    logic [63:0] q;
    int          nn;
    int          i;
    nn = n;
    if (nn < 1) nn = 1;
    if (nn > VR2D_MAX_ITER) nn = VR2D_MAX_ITER;
    p = 64'd1 << 60;
    for (i = 0; i < VR2D_MAX_ITER; i++) begin
      if (i < nn) p = p + (p >> (2 * i));
    end
    v     = p;
    res   = '0;
    bit_m = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bit_m > v) bit_m = bit_m >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (bit_m != 0) begin
        if (v >= res + bit_m) begin
          v   = v - (res + bit_m);
          res = (res >> 1) + bit_m;
        end else begin
          res = res >> 1;
        end
        bit_m = bit_m >> 2;
      end
    end
    if (res == 0) return VR2D_KW'(64'd1 << 30);
    // restoring division of 2^60 by res
    rem = '0;
    q   = '0;
    for (i = 60; i >= 0; i--) begin
      rem = {rem[62:0], (i == 60)};
      if (rem >= res) begin
        rem  = rem - res;
        q[i] = 1'b1;
      end
    end
    return q[VR2D_KW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vector_rotate_2d.sv
// ----------------------------------------------------------------------------
// vector_rotate_2d
// Fixed-point CORDIC rotation of a Q15.16 vector by a Q3.28 angle.
// ----------------------------------------------------------------------------
// Usage: the block takes one item in every clock cycle; busy is always low,
// so an item is taken whenever start is high. Each item yields exactly one
// result, in order, on out_x_out/out_y_out with out_valid high for one cycle.
// Each item passes through four preparation stages (reduce, fold, multiply,
// scale), then the unrolled chain of ITERATIONS rotation cells and one
// rounding stage. The receiver cannot stall the block and must take every
// result in the cycle it appears. Results saturate to the 32-bit range.
`default_nettype none
`include "vector_rotate_2d_defines.svh"

module vector_rotate_2d
  import vr2d_pkg::*;
#(
  parameter int ITERATIONS = VR2D_ITERATIONS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VR2D_IW-1:0] in_x_in,
  input  logic signed [VR2D_IW-1:0] in_y_in,
  input  logic signed [VR2D_IW-1:0] in_angle,
  output logic                      out_valid,
  output logic signed [VR2D_IW-1:0] out_x_out,
  output logic signed [VR2D_IW-1:0] out_y_out
);

  localparam int LAT = ITERATIONS + 5;

  logic      accept;
  logic      vld_c [ITERATIONS+1];
  vr2d_vec_t vec_c [ITERATIONS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  vr2d_prep #(
    .ITERATIONS (ITERATIONS)
  ) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (accept),
    .x_i   (in_x_in),
    .y_i   (in_y_in),
    .ang_i (in_angle),
    .vld_o (vld_c[0]),
    .vec_o (vec_c[0])
  );

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    vr2d_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_c[g]),
      .vec_i (vec_c[g]),
      .vld_o (vld_c[g+1]),
      .vec_o (vec_c[g+1])
    );
  end

  vr2d_finish u_finish (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_c[ITERATIONS]),
    .vec_i (vec_c[ITERATIONS]),
    .vld_o (out_valid),
    .x_o   (out_x_out),
    .y_o   (out_y_out)
  );

  // every taken item yields a result, and no result comes without an item
  `VR2D_ASSERT_DLY(a_lat_fwd, accept, LAT, out_valid)
  `VR2D_ASSERT_IMM(a_lat_bwd, out_valid, $past(accept, LAT))

endmodule

`default_nettype wire

// File: rtl/core/vr2d_prep.sv
// ----------------------------------------------------------------------------
// vr2d_prep
// Angle reduction, quadrant fold and gain pre-scale, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector_rotate_2d_defines.svh"

module vr2d_prep
  import vr2d_pkg::*;
#(
  parameter int ITERATIONS = VR2D_ITERATIONS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic signed [VR2D_IW-1:0] x_i,
  input  logic signed [VR2D_IW-1:0] y_i,
  input  logic signed [VR2D_IW-1:0] ang_i,
  output logic                      vld_o,
  output vr2d_vec_t                 vec_o
);

  localparam int PW  = (VR2D_IW + 1) + (VR2D_KW + 1);
  localparam int SCL = 30 - VR2D_GUARD;
  localparam logic signed [VR2D_KW:0] K_S   = {1'b0, vr2d_gain_k(ITERATIONS)};
  localparam logic signed [PW-1:0]    RND_S = PW'(64'sd1 << (SCL - 1));

  logic [3:0] vld_r;

  // stage A: reduce
  logic signed [VR2D_ZW:0]   ang_ext;
  logic signed [VR2D_ZW:0]   za_nxt;
  logic signed [VR2D_IW-1:0] xa_r, ya_r;
  logic signed [VR2D_ZW-1:0] za_r;

  // stage B: fold
  logic signed [VR2D_ZW:0]   za_ext;
  logic signed [VR2D_IW:0]   xa_ext, ya_ext;
  logic signed [VR2D_IW:0]   xb_nxt, yb_nxt;
  logic signed [VR2D_ZW:0]   zb_nxt;
  logic signed [VR2D_IW:0]   xb_r, yb_r;
  logic signed [VR2D_ZW-1:0] zb_r;

  // stage C: multiply
  logic signed [PW-1:0]      pxc_nxt, pyc_nxt;
  logic signed [PW-1:0]      pxc_r, pyc_r;
  logic signed [VR2D_ZW-1:0] zc_r;

  // stage D: round to Q.32
  logic signed [PW-1:0]      xs_full, ys_full;
  vr2d_vec_t                 vec_r;

  assign ang_ext = {ang_i[VR2D_IW-1], ang_i};

  always_comb begin
    if (ang_ext > VR2D_ANG_PI) begin
      za_nxt = ang_ext - VR2D_ANG_TWO_PI;
    end else if (ang_ext < -VR2D_ANG_PI) begin
      za_nxt = ang_ext + VR2D_ANG_TWO_PI;
    end else begin
      za_nxt = ang_ext;
    end
  end

  assign za_ext = {za_r[VR2D_ZW-1], za_r};
  assign xa_ext = {xa_r[VR2D_IW-1], xa_r};
  assign ya_ext = {ya_r[VR2D_IW-1], ya_r};

  always_comb begin
    if (za_ext > VR2D_ANG_HALF_PI) begin
      xb_nxt = -ya_ext;
      yb_nxt = xa_ext;
      zb_nxt = za_ext - VR2D_ANG_HALF_PI;
    end else if (za_ext < -VR2D_ANG_HALF_PI) begin
      xb_nxt = ya_ext;
      yb_nxt = -xa_ext;
      zb_nxt = za_ext + VR2D_ANG_HALF_PI;
    end else begin
      xb_nxt = xa_ext;
      yb_nxt = ya_ext;
      zb_nxt = za_ext;
    end
  end

  assign pxc_nxt = xb_r * K_S;
  assign pyc_nxt = yb_r * K_S;

  assign xs_full = (pxc_r + RND_S) >>> SCL;
  assign ys_full = (pyc_r + RND_S) >>> SCL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    xa_r    <= x_i;
    ya_r    <= y_i;
    za_r    <= za_nxt[VR2D_ZW-1:0];
    xb_r    <= xb_nxt;
    yb_r    <= yb_nxt;
    zb_r    <= zb_nxt[VR2D_ZW-1:0];
    pxc_r   <= pxc_nxt;
    pyc_r   <= pyc_nxt;
    zc_r    <= zb_r;
    vec_r.x <= xs_full[VR2D_DW-1:0];
    vec_r.y <= ys_full[VR2D_DW-1:0];
    vec_r.z <= zc_r;
  end

  assign vld_o = vld_r[3];
  assign vec_o = vec_r;

  // folded angle stays inside the CORDIC range; an angle of exactly pi
  // folds to one step past half pi
  `VR2D_ASSERT_IMM(a_fold_range, vld_r[1],
    (zb_r <= VR2D_ANG_PI - VR2D_ANG_HALF_PI) && (zb_r >= VR2D_ANG_HALF_PI - VR2D_ANG_PI))

endmodule

`default_nettype wire

// File: rtl/core/vr2d_cell.sv
// ----------------------------------------------------------------------------
// vr2d_cell
// One CORDIC micro-rotation with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vr2d_cell
  import vr2d_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld_i,
  input  vr2d_vec_t vec_i,
  output logic      vld_o,
  output vr2d_vec_t vec_o
);

  localparam logic signed [VR2D_ZW-1:0] ATAN_S = vr2d_atan(SHIFT);

  logic signed [VR2D_DW-1:0] xi, yi, dx, dy;
  logic signed [VR2D_ZW-1:0] zi;
  logic                      vld_r;
  vr2d_vec_t                 vec_nxt, vec_r;

  assign xi = vec_i.x;
  assign yi = vec_i.y;
  assign zi = vec_i.z;
  assign dx = yi >>> SHIFT;
  assign dy = xi >>> SHIFT;

  // rotate toward zero residual angle
  always_comb begin
    if (!zi[VR2D_ZW-1]) begin
      vec_nxt.x = xi - dx;
      vec_nxt.y = yi + dy;
      vec_nxt.z = zi - ATAN_S;
    end else begin
      vec_nxt.x = xi + dx;
      vec_nxt.y = yi - dy;
      vec_nxt.z = zi + ATAN_S;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign vld_o = vld_r;
  assign vec_o = vec_r;

endmodule

`default_nettype wire

// File: rtl/core/vr2d_finish.sv
// ----------------------------------------------------------------------------
// vr2d_finish
// Round Q.32 back to Q15.16, saturate to 32 bits and register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vr2d_finish
  import vr2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  vr2d_vec_t                 vec_i,
  output logic                      vld_o,
  output logic signed [VR2D_IW-1:0] x_o,
  output logic signed [VR2D_IW-1:0] y_o
);

  localparam logic signed [VR2D_DW-1:0] RND_S  = VR2D_DW'(64'sd1 << (VR2D_GUARD - 1));
  localparam logic signed [VR2D_DW-1:0] SAT_HI = VR2D_DW'(64'sd2147483647);
  localparam logic signed [VR2D_DW-1:0] SAT_LO = VR2D_DW'(-64'sd2147483648);

  function automatic logic signed [VR2D_IW-1:0] round_sat(
    input logic signed [VR2D_DW-1:0] v
  );
    logic signed [VR2D_DW-1:0] r;
    r = (v + RND_S) >>> VR2D_GUARD;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[VR2D_IW-1:0];
  endfunction

  logic                      vld_r;
  logic signed [VR2D_IW-1:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= round_sat(vec_i.x);
    y_r <= round_sat(vec_i.y);
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule

`default_nettype wire

// File: tb/vector_rotate_2d_checker.sv
// ----------------------------------------------------------------------------
// vector_rotate_2d checker
// Watches the item and result channels of the rotator. It predicts each
// rotated vector in fixed point, then compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector_rotate_2d_checker
  import vr2d_pkg::*;
#(
  parameter int ITERATIONS = VR2D_ITERATIONS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [VR2D_IW-1:0] in_x_in,
  input  logic signed [VR2D_IW-1:0] in_y_in,
  input  logic signed [VR2D_IW-1:0] in_angle,
  input  logic                      out_valid,
  input  logic signed [VR2D_IW-1:0] out_x_out,
  input  logic signed [VR2D_IW-1:0] out_y_out,
  output int                        errors,
  output int                        pending,
  output int                        checked,
  output int                        wraps,
  output int                        folds,
  output int                        clips
);

  localparam int N_ROT = (ITERATIONS < 1) ? 1 :
                         (ITERATIONS > VR2D_MAX_ITER) ? VR2D_MAX_ITER : ITERATIONS;

  localparam longint ANG_PI   = longint'(VR2D_ANG_PI);
  localparam longint ANG_HALF = longint'(VR2D_ANG_HALF_PI);
  localparam longint ANG_TWO  = longint'(VR2D_ANG_TWO_PI);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rot_t;

  rot_t   rotated_q[$];
  longint gain_k;
  longint atan_q28 [0:31];

  initial begin : setup
    longint unsigned p, v, root, bit_m;
    atan_q28 = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
                 16, 8, 4, 2, 1, 0, 0, 0};
    // gain product in Q.60, then K = 2^60 / floor(sqrt(P))
    p = 64'd1 << 60;
    for (int i = 0; i < N_ROT; i++) p = p + (p >> (2 * i));
    v     = p;
    root  = 0;
    bit_m = 64'd1 << 62;
    while (bit_m > v) bit_m = bit_m >> 2;
    while (bit_m != 0) begin
      if (v >= root + bit_m) begin
        v    = v - (root + bit_m);
        root = (root >> 1) + bit_m;
      end else begin
        root = root >> 1;
      end
      bit_m = bit_m >> 2;
    end
    gain_k = (root == 0) ? (64'sd1 << 30) : longint'((64'd1 << 60) / root);
  end

  function automatic rot_t rotate_vector(input logic signed [31:0] xi,
                                         input logic signed [31:0] yi,
                                         input logic signed [31:0] ai,
                                         output bit wrapped,
                                         output bit folded,
                                         output bit clipped);
    longint x, y, z, t, dx, dy, r;
    longint v [0:1];
    rot_t   res;
    x = xi;
    y = yi;
    z = ai;
    wrapped = 1'b0;
    folded  = 1'b1;
    clipped = 1'b0;
    if (z > ANG_PI) begin
      z = z - ANG_TWO;
      wrapped = 1'b1;
    end else if (z < -ANG_PI) begin
      z = z + ANG_TWO;
      wrapped = 1'b1;
    end
    // quarter turn brings the angle into the CORDIC range
    if (z > ANG_HALF) begin
      t = x; x = -y; y = t;
      z = z - ANG_HALF;
    end else if (z < -ANG_HALF) begin
      t = x; x = y; y = -t;
      z = z + ANG_HALF;
    end else begin
      folded = 1'b0;
    end
    x = (x * gain_k + 64'sd8192) >>> 14;
    y = (y * gain_k + 64'sd8192) >>> 14;
    for (int i = 0; i < N_ROT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_q28[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_q28[i];
      end
    end
    v[0] = x;
    v[1] = y;
    for (int j = 0; j < 2; j++) begin
      r = (v[j] + 64'sd32768) >>> 16;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        clipped = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        clipped = 1'b1;
      end
      v[j] = r;
    end
    res.x = v[0][31:0];
    res.y = v[1][31:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rot_t want;
    rot_t got;
    bit   w, f, c;
    if (rst_n) begin
      if (out_valid) begin
        got.x = out_x_out;
        got.y = out_y_out;
        if (rotated_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result x_out %0d y_out %0d", $time, got.x, got.y);
        end else begin
          want    = rotated_q.pop_front();
          checked = checked + 1;
          if (want.x !== got.x) begin
            errors = errors + 1;
            $display("%0t: x_out expected %0d got %0d", $time, want.x, got.x);
          end
          if (want.y !== got.y) begin
            errors = errors + 1;
            $display("%0t: y_out expected %0d got %0d", $time, want.y, got.y);
          end
        end
      end
      if (start && !busy) begin
        rotated_q.push_back(rotate_vector(in_x_in, in_y_in, in_angle, w, f, c));
        wraps = wraps + w;
        folds = folds + f;
        clips = clips + c;
      end
      pending = rotated_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// vector_rotate_2d testbench
// Drives directed and random vectors and angles into the rotator, with
// random gaps between items, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import vr2d_pkg::*;
();

  localparam int ITEMS    = 750;
  localparam int WATCHDOG = 4000;

  localparam int A_PI   = int'(VR2D_ANG_PI);
  localparam int A_HALF = int'(VR2D_ANG_HALF_PI);

  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_x_in = '0;
  logic [31:0] in_y_in = '0;
  logic [31:0] in_angle = '0;
  logic        out_valid;
  logic [31:0] out_x_out;
  logic [31:0] out_y_out;

  int errors, pending, checked, wraps, folds, clips;
  int sent;
  int idle_cycles;

  always #10 clk = ~clk;

  vector_rotate_2d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_x_out (out_x_out),
    .out_y_out (out_y_out)
  );

  vector_rotate_2d_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_x_out (out_x_out),
    .out_y_out (out_y_out),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .wraps     (wraps),
    .folds     (folds),
    .clips     (clips)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge that takes the item
  task automatic push(input logic [31:0] x, input logic [31:0] y, input logic [31:0] a);
    in_x_in  <= x;
    in_y_in  <= y;
    in_angle <= a;
    start    <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // hold start low for a random gap, which may be none, or for none inside a steady burst
  task automatic pause(input bit steady);
    int gap;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
      else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      6: begin
        case ($urandom_range(0, 4))
          0: v = MAXV;
          1: v = MINV;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      7: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_angle();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: begin
        case ($urandom_range(0, 4))
          0: v = A_PI;
          1: v = -A_PI;
          2: v = A_HALF;
          3: v = -A_HALF;
          default: v = '0;
        endcase
        v = v + $urandom_range(0, 8) - 32'd4;
      end
      6: v = $urandom_range(0, 1) ? MAXV : MINV;
      default: v = $urandom_range(0, 2 * A_PI) - A_PI;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    bit steady;
    int burst;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, wrap and fold boundaries, saturation
    push('0, '0, '0);
    push(ONE, '0, A_HALF);
    push(ONE, '0, A_PI);
    push(ONE, '0, A_PI + 1);
    push(ONE, '0, -A_PI);
    push(ONE, '0, -A_PI - 1);
    push(ONE, 2 * ONE, A_HALF + 1);
    push(ONE, 2 * ONE, -A_HALF);
    push(ONE, 2 * ONE, -A_HALF - 1);
    push(MAXV, MAXV, A_PI / 4);
    push(MINV, MINV, A_PI / 4);
    push(MAXV, MINV, MAXV);
    push(MINV, MAXV, MINV);
    push(MINV, MINV, A_PI);
    push('1, 32'd1, 32'd1);
    push(MAXV, '0, -A_HALF / 2);
    push(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    pause(1'b0);
    push(MINV, '0, A_HALF);
    pause(1'b0);
    push('0, MINV, -A_HALF);

    while (sent < ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      burst  = $urandom_range(1, 30);
      repeat (burst) begin
        pause(steady);
        push(rand_coord(), rand_coord(), rand_angle());
      end
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (VR2D_ITERATIONS + 10) @(posedge clk);

    $display("%0d items sent, %0d results checked", sent, checked);
    $display("angle wraps %0d, quadrant folds %0d, saturated results %0d",
             wraps, folds, clips);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
